/* src/sjfq_pkg.sv */
// shared types and codes for the shortest-job-first queue
package sjfq_pkg;

   // request kinds
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   // result status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // width of the reported occupancy field
   localparam int OCC_BITS = 6;

   // per-cycle update command broadcast to every slot cell
   typedef struct packed {
      logic insert_en;
      logic remove_en;
   } cell_ctrl_type;

endpackage

/* src/sjfq_cell.sv */
// one slot of the sorted queue: holds a job and picks its next value from its neighbours
module sjfq_cell import sjfq_pkg::*; #(
   parameter int LENGTH_BITS = 10,
   parameter int OWNER_BITS  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cell_ctrl_type          ctrl,
   input  logic [LENGTH_BITS-1:0] new_length,
   input  logic [OWNER_BITS-1:0]  new_owner,
   input  logic                   prev_lt,
   input  logic [LENGTH_BITS-1:0] prev_length,
   input  logic [OWNER_BITS-1:0]  prev_owner,
   input  logic                   prev_valid,
   input  logic [LENGTH_BITS-1:0] next_length,
   input  logic [OWNER_BITS-1:0]  next_owner,
   input  logic                   next_valid,
   output logic [LENGTH_BITS-1:0] length,
   output logic [OWNER_BITS-1:0]  owner,
   output logic                   valid,
   output logic                   lt
);

   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic [OWNER_BITS-1:0]  owner_ff, owner_in;
   logic                   valid_ff, valid_in;

   // held job is strictly shorter than the incoming one: it stays ahead
   assign lt = valid_ff && (length_ff < new_length);

   always_comb begin
      length_in = length_ff;
      owner_in  = owner_ff;
      valid_in  = valid_ff;
      if (ctrl.remove_en) begin
         length_in = next_length;
         owner_in  = next_owner;
         valid_in  = next_valid;
      end else if (ctrl.insert_en && !lt) begin
         if (prev_lt) begin
            length_in = new_length;
            owner_in  = new_owner;
            valid_in  = 1'b1;
         end else begin
            length_in = prev_length;
            owner_in  = prev_owner;
            valid_in  = prev_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      length_ff <= length_in;
      owner_ff  <= owner_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign length = length_ff;
   assign owner  = owner_ff;
   assign valid  = valid_ff;

endmodule

/* src/shortest_job_first_queue_core.sv */
// top level of the shortest-job-first queue: request register, slot row, result register
//
// Usage: each request on the req_ channel either inserts a job (req_action insert,
// with req_job_length and req_job_owner) or removes the shortest held job. Jobs sit
// in a row of slot cells kept in ascending length order; among equal lengths the most
// recently inserted job leaves first. Every request yields exactly one response on the
// rsp_ channel carrying a status (done, full, empty), the removed job or zeros, and
// the number of jobs held afterwards.
// Path: a request accepted into the request register is worked on by the parallel
// compare and shift of all cells, and its response is loaded into the result register
// at the same edge as the slot row updates.
// Throughput: one request per cycle unless rsp_stall holds a response; the whole
// compare-and-shift of the slot row works in parallel, so requests wait only on rsp_stall.
// Reset: synchronous, clears all slot valid bits, the job count and both channel
// valids; the queue starts empty.
// Stall: while rsp_stall holds a response, the held request waits and req_stall
// rises; the queue contents do not change until the response is taken.
module shortest_job_first_queue_core import sjfq_pkg::*; #(
   parameter int QUEUE_DEPTH = 32,
   parameter int LENGTH_BITS = 10,
   parameter int OWNER_BITS  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [LENGTH_BITS-1:0] req_job_length,
   input  logic [OWNER_BITS-1:0]  req_job_owner,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [LENGTH_BITS-1:0] rsp_removed_length,
   output logic [OWNER_BITS-1:0]  rsp_removed_owner,
   output logic [OCC_BITS-1:0]    rsp_occupancy
);

   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // request register
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_action_ff;
   logic [LENGTH_BITS-1:0] s1_length_ff;
   logic [OWNER_BITS-1:0]  s1_owner_ff;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [LENGTH_BITS-1:0] rsp_length_ff, rsp_length_in;
   logic [OWNER_BITS-1:0]  rsp_owner_ff, rsp_owner_in;
   logic [OCC_BITS-1:0]    rsp_occ_ff, rsp_occ_in;

   logic [CNT_BITS-1:0]    count_ff, count_in;

   logic [LENGTH_BITS-1:0] slot_length [QUEUE_DEPTH];
   logic [OWNER_BITS-1:0]  slot_owner  [QUEUE_DEPTH];
   logic                   slot_valid  [QUEUE_DEPTH];
   logic                   slot_lt     [QUEUE_DEPTH];

   logic          advance;
   logic          fire;
   logic          full;
   logic          empty;
   cell_ctrl_type ctrl;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;

   assign full  = slot_valid[QUEUE_DEPTH-1];
   assign empty = !slot_valid[0];

   assign ctrl.insert_en = fire && (s1_action_ff == ACT_INSERT) && !full;
   assign ctrl.remove_en = fire && (s1_action_ff == ACT_REMOVE) && !empty;

   genvar i;
   generate
      for (i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
         logic                   p_lt;
         logic [LENGTH_BITS-1:0] p_length;
         logic [OWNER_BITS-1:0]  p_owner;
         logic                   p_valid;
         logic [LENGTH_BITS-1:0] n_length;
         logic [OWNER_BITS-1:0]  n_owner;
         logic                   n_valid;

         if (i == 0) begin : g_first
            // head slot always takes the new job unless it keeps its own
            assign p_lt     = 1'b1;
            assign p_length = '0;
            assign p_owner  = '0;
            assign p_valid  = 1'b0;
         end else begin : g_mid
            assign p_lt     = slot_lt[i-1];
            assign p_length = slot_length[i-1];
            assign p_owner  = slot_owner[i-1];
            assign p_valid  = slot_valid[i-1];
         end

         if (i == QUEUE_DEPTH - 1) begin : g_last
            assign n_length = '0;
            assign n_owner  = '0;
            assign n_valid  = 1'b0;
         end else begin : g_inner
            assign n_length = slot_length[i+1];
            assign n_owner  = slot_owner[i+1];
            assign n_valid  = slot_valid[i+1];
         end

         sjfq_cell #(
            .LENGTH_BITS (LENGTH_BITS),
            .OWNER_BITS  (OWNER_BITS)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .new_length  (s1_length_ff),
            .new_owner   (s1_owner_ff),
            .prev_lt     (p_lt),
            .prev_length (p_length),
            .prev_owner  (p_owner),
            .prev_valid  (p_valid),
            .next_length (n_length),
            .next_owner  (n_owner),
            .next_valid  (n_valid),
            .length      (slot_length[i]),
            .owner       (slot_owner[i]),
            .valid       (slot_valid[i]),
            .lt          (slot_lt[i])
         );
      end
   endgenerate

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert_en) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (ctrl.remove_en) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_comb begin
      rsp_status_in = ST_DONE;
      rsp_length_in = '0;
      rsp_owner_in  = '0;
      if (s1_action_ff == ACT_INSERT) begin
         if (full) begin
            rsp_status_in = ST_FULL;
         end
      end else if (empty) begin
         rsp_status_in = ST_EMPTY;
      end else begin
         rsp_length_in = slot_length[0];
         rsp_owner_in  = slot_owner[0];
      end
      rsp_occ_in = OCC_BITS'(count_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_action_ff <= req_action;
         s1_length_ff <= req_job_length;
         s1_owner_ff  <= req_job_owner;
      end
      if (fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_length_ff <= rsp_length_in;
         rsp_owner_ff  <= rsp_owner_in;
         rsp_occ_ff    <= rsp_occ_in;
      end
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_removed_length = rsp_length_ff;
   assign rsp_removed_owner  = rsp_owner_ff;
   assign rsp_occupancy      = rsp_occ_ff;

endmodule

/* bench/tb_shortest_job_first_queue_core.sv */
// self-checking testbench for the shortest-job-first queue core
module tb_shortest_job_first_queue_core import sjfq_pkg::*;;

   localparam int QUEUE_DEPTH = 32;
   localparam int LENGTH_BITS = 10;
   localparam int OWNER_BITS  = 8;
   localparam int RANDOM_REQUESTS = 1800;

   typedef struct {
      logic                   action;
      logic [LENGTH_BITS-1:0] length;
      logic [OWNER_BITS-1:0]  owner;
   } job_request_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [LENGTH_BITS-1:0] removed_length;
      logic [OWNER_BITS-1:0]  removed_owner;
      logic [OCC_BITS-1:0]    occupancy;
   } job_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_action = ACT_INSERT;
   logic [LENGTH_BITS-1:0] req_job_length = '0;
   logic [OWNER_BITS-1:0]  req_job_owner = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [1:0]             rsp_status;
   logic [LENGTH_BITS-1:0] rsp_removed_length;
   logic [OWNER_BITS-1:0]  rsp_removed_owner;
   logic [OCC_BITS-1:0]    rsp_occupancy;

   // queue contents as the bench expects them, shortest first
   logic [LENGTH_BITS-1:0] held_length [QUEUE_DEPTH];
   logic [OWNER_BITS-1:0]  held_owner [QUEUE_DEPTH];
   int                     held_jobs = 0;

   job_request_type job_requests [$];
   job_result_type  awaited_results [$];
   job_request_type next_job;
   job_result_type  awaited;
   int              total_requests = 0;
   int              accepted_requests = 0;
   int              mismatches = 0;
   int              cycle_count = 0;
   logic            quiet_span;

   shortest_job_first_queue_core #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .LENGTH_BITS(LENGTH_BITS),
      .OWNER_BITS (OWNER_BITS)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_job_length    (req_job_length),
      .req_job_owner     (req_job_owner),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_length(rsp_removed_length),
      .rsp_removed_owner (rsp_removed_owner),
      .rsp_occupancy     (rsp_occupancy)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // a long stretch where neither side idles
   assign quiet_span = (cycle_count >= 1000) && (cycle_count < 2500);

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %0h, want %0h (cycle %0d)", what, got, want, cycle_count);
      mismatches++;
   endtask

   task automatic add_request(logic action, logic [LENGTH_BITS-1:0] length,
                              logic [OWNER_BITS-1:0] owner);
      job_request_type r;
      r.action = action;
      r.length = length;
      r.owner  = owner;
      job_requests.push_back(r);
      total_requests++;
   endtask

   // applies one request to the expected queue and returns its response
   function automatic job_result_type predict_queue_outcome(job_request_type r);
      job_result_type res;
      int             pos;
      res = '0;
      res.status = ST_DONE;
      if (r.action == ACT_INSERT) begin
         if (held_jobs >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            // new job goes ahead of every held job of equal or greater length
            pos = 0;
            while (pos < held_jobs && held_length[pos] < r.length) pos++;
            for (int i = held_jobs; i > pos; i--) begin
               held_length[i] = held_length[i-1];
               held_owner[i]  = held_owner[i-1];
            end
            held_length[pos] = r.length;
            held_owner[pos]  = r.owner;
            held_jobs++;
         end
      end else begin
         if (held_jobs == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.removed_length = held_length[0];
            res.removed_owner  = held_owner[0];
            for (int i = 0; i + 1 < held_jobs; i++) begin
               held_length[i] = held_length[i+1];
               held_owner[i]  = held_owner[i+1];
            end
            held_jobs--;
         end
      end
      res.occupancy = OCC_BITS'(held_jobs);
      return res;
   endfunction

   function automatic logic [LENGTH_BITS-1:0] pick_length();
      case ($urandom_range(0, 3))
         0: pick_length = LENGTH_BITS'($urandom);
         1: pick_length = LENGTH_BITS'($urandom_range(0, 7));
         2: pick_length = $urandom_range(0, 1) ? '1 : '0;
         default: pick_length = LENGTH_BITS'($urandom_range(0, 63));
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            next_job.action = req_action;
            next_job.length = req_job_length;
            next_job.owner  = req_job_owner;
            awaited_results.push_back(predict_queue_outcome(next_job));
            accepted_requests++;
         end
         if (!req_valid || !req_stall) begin
            if (job_requests.size() != 0 && (quiet_span || $urandom_range(0, 99) >= 30)) begin
               next_job = job_requests.pop_front();
               req_valid      <= 1'b1;
               req_action     <= next_job.action;
               req_job_length <= next_job.length;
               req_job_owner  <= next_job.owner;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !quiet_span && ($urandom_range(0, 99) < 30);
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("unawaited response status", 32'(rsp_status), '0);
         end else begin
            awaited = awaited_results.pop_front();
            if (rsp_status !== awaited.status)
               report_mismatch("status", 32'(rsp_status), 32'(awaited.status));
            if (rsp_removed_length !== awaited.removed_length)
               report_mismatch("removed_length", 32'(rsp_removed_length),
                               32'(awaited.removed_length));
            if (rsp_removed_owner !== awaited.removed_owner)
               report_mismatch("removed_owner", 32'(rsp_removed_owner),
                               32'(awaited.removed_owner));
            if (rsp_occupancy !== awaited.occupancy)
               report_mismatch("occupancy", 32'(rsp_occupancy), 32'(awaited.occupancy));
         end
      end
   end

   initial begin
      int produced;
      int seg_len;
      int insert_pct;

      // empty remove, zero-length and maximal jobs, ties, then drain past empty
      add_request(ACT_REMOVE, '1, '1);
      add_request(ACT_INSERT, '0, '0);
      add_request(ACT_INSERT, '1, '1);
      add_request(ACT_INSERT, 10'd5, 8'd1);
      add_request(ACT_INSERT, 10'd5, 8'd2);
      add_request(ACT_INSERT, 10'd5, 8'd3);
      add_request(ACT_INSERT, '0, 8'hAA);
      add_request(ACT_INSERT, 10'h2AA, 8'h55);
      add_request(ACT_INSERT, 10'h155, 8'hAA);
      for (int i = 0; i < 9; i++) add_request(ACT_REMOVE, LENGTH_BITS'(i), 8'h5A);

      // bursts that mostly fill, mostly drain or mix, so full and empty recur
      produced = 0;
      while (produced < RANDOM_REQUESTS) begin
         seg_len = $urandom_range(8, 48);
         case ($urandom_range(0, 2))
            0: insert_pct = 85;
            1: insert_pct = 15;
            default: insert_pct = 50;
         endcase
         for (int i = 0; i < seg_len; i++) begin
            add_request(($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_REMOVE,
                        pick_length(), OWNER_BITS'($urandom));
         end
         produced += seg_len;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (accepted_requests < total_requests || awaited_results.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
